// ===== sv/rgb2hsv_pkg.sv =====
// Package with constants and the pipeline stage type of the RGB to HSV converter.
`timescale 1ns / 1ps

package rgb2hsv_pkg;

    localparam int ChanW      = 8;
    localparam int DataW      = 3 * ChanW;
    localparam int SatBits    = 8;
    localparam int HueBits    = 6;
    localparam int NumStages  = 2 + SatBits;
    localparam int HueNumW    = ChanW + HueBits;

    localparam logic [ChanW-1:0] Sector    = 8'd43;
    localparam logic [ChanW-1:0] BaseRed   = 8'd0;
    localparam logic [ChanW-1:0] BaseGreen = 8'd85;
    localparam logic [ChanW-1:0] BaseBlue  = 8'd171;

    typedef struct packed {
        logic [ChanW-1:0]   hi;
        logic [ChanW-1:0]   chroma;
        logic [ChanW-1:0]   base;
        logic               neg;
        logic [ChanW-1:0]   adiff;
        logic [ChanW-1:0]   sat_rem;
        logic [SatBits-1:0] sat_low;
        logic [SatBits-1:0] sat_q;
        logic [ChanW-1:0]   hue_rem;
        logic [HueBits-1:0] hue_low;
        logic [HueBits-1:0] hue_q;
    } stage_t;

endpackage

// ===== sv/rgb_to_hsv_converter_core.sv =====
// Top level of the pipelined 8-bit RGB to HSV converter.
`timescale 1ns / 1ps

// The core takes one RGB pixel per clock while the output side does not stall and gives
// hue, saturation and brightness (value) through a front stage, a numerator stage, the eight
// restoring division stages that form the saturation quotient one bit per stage, and an
// output register; the hue quotient is formed in the first six division stages in parallel.
// Each stage holds its item while the stage after it cannot take it, so a stall on the
// output stops only the stages that are occupied and bubbles are filled from the input side.
module rgb_to_hsv_converter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // hue [7:0], saturation [15:8], brightness [23:16]
);

    localparam int N  = rgb2hsv_pkg::NumStages;
    localparam int CW = rgb2hsv_pkg::ChanW;

    rgb2hsv_pkg::stage_t stage_reg  [N];
    rgb2hsv_pkg::stage_t stage_next [N];
    logic [N-1:0]        valid_reg;
    logic [N:0]          rdy;

    logic [rgb2hsv_pkg::DataW-1:0] out_data_reg;
    logic [rgb2hsv_pkg::DataW-1:0] out_data_next;
    logic                          out_valid_reg;

    function automatic rgb2hsv_pkg::stage_t front_stage(input logic [23:0] pix);
        rgb2hsv_pkg::stage_t s;
        logic [CW-1:0] r, g, b, hi, lo;
        logic [CW:0]   d;
        begin
            r  = pix[7:0];
            g  = pix[15:8];
            b  = pix[23:16];
            hi = (r > g) ? r : g;
            hi = (hi > b) ? hi : b;
            lo = (r < g) ? r : g;
            lo = (lo < b) ? lo : b;
            s  = '0;
            if (hi == r) begin
                s.base = rgb2hsv_pkg::BaseRed;
                d      = {1'b0, g} - {1'b0, b};
            end else if (hi == g) begin
                s.base = rgb2hsv_pkg::BaseGreen;
                d      = {1'b0, b} - {1'b0, r};
            end else begin
                s.base = rgb2hsv_pkg::BaseBlue;
                d      = {1'b0, r} - {1'b0, g};
            end
            s.hi     = hi;
            s.chroma = hi - lo;
            s.neg    = d[CW];
            s.adiff  = d[CW] ? CW'(-d) : d[CW-1:0];
            return s;
        end
    endfunction

    function automatic rgb2hsv_pkg::stage_t numer_stage(input rgb2hsv_pkg::stage_t p);
        rgb2hsv_pkg::stage_t s;
        logic [2*CW-1:0]                  snum;
        logic [rgb2hsv_pkg::HueNumW-1:0]  hnum;
        begin
            s         = p;
            snum      = {p.chroma, {CW{1'b0}}} - {{CW{1'b0}}, p.chroma};
            hnum      = rgb2hsv_pkg::HueNumW'(p.adiff)
                        * rgb2hsv_pkg::HueNumW'(rgb2hsv_pkg::Sector);
            s.sat_rem = snum[2*CW-1:CW];
            s.sat_low = snum[CW-1:0];
            s.hue_rem = hnum[rgb2hsv_pkg::HueNumW-1:rgb2hsv_pkg::HueBits];
            s.hue_low = hnum[rgb2hsv_pkg::HueBits-1:0];
            s.sat_q   = '0;
            s.hue_q   = '0;
            return s;
        end
    endfunction

    function automatic rgb2hsv_pkg::stage_t div_stage(input rgb2hsv_pkg::stage_t p,
                                                      input logic do_hue);
        rgb2hsv_pkg::stage_t s;
        logic [CW:0] ts;
        logic [CW:0] th;
        logic        qs;
        logic        qh;
        begin
            s  = p;
            ts = {p.sat_rem, p.sat_low[rgb2hsv_pkg::SatBits-1]};
            qs = (ts >= {1'b0, p.hi});
            s.sat_rem = qs ? CW'(ts - {1'b0, p.hi}) : ts[CW-1:0];
            s.sat_low = {p.sat_low[rgb2hsv_pkg::SatBits-2:0], 1'b0};
            s.sat_q   = {p.sat_q[rgb2hsv_pkg::SatBits-2:0], qs};
            if (do_hue) begin
                th = {p.hue_rem, p.hue_low[rgb2hsv_pkg::HueBits-1]};
                qh = (th >= {1'b0, p.chroma});
                s.hue_rem = qh ? CW'(th - {1'b0, p.chroma}) : th[CW-1:0];
                s.hue_low = {p.hue_low[rgb2hsv_pkg::HueBits-2:0], 1'b0};
                s.hue_q   = {p.hue_q[rgb2hsv_pkg::HueBits-2:0], qh};
            end
            return s;
        end
    endfunction

    always_comb begin
        stage_next[0] = front_stage(s_tdata);
        stage_next[1] = numer_stage(stage_reg[0]);
        for (int k = 2; k < N; k++) begin
            stage_next[k] = div_stage(stage_reg[k-1], (k - 2) < rgb2hsv_pkg::HueBits);
        end
    end

    always_comb begin
        logic [CW-1:0] q8;
        logic [CW-1:0] hue;
        rgb2hsv_pkg::stage_t p;
        p   = stage_reg[N-1];
        q8  = CW'(p.hue_q);
        hue = p.base + (p.neg ? CW'(-q8) : q8);
        if (p.hi == '0) begin
            out_data_next = {p.hi, {CW{1'b0}}, {CW{1'b0}}};
        end else if (p.sat_q == '0) begin
            out_data_next = {p.hi, p.sat_q, {CW{1'b0}}};
        end else begin
            out_data_next = {p.hi, p.sat_q, hue};
        end
    end

    always_comb begin
        rdy[N] = !out_valid_reg || m_tready;
        for (int k = N - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < N; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (rdy[N]) begin
                out_valid_reg <= valid_reg[N-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (rdy[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
        if (rdy[N]) begin
            out_data_reg <= out_data_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/rgb2hsv_checker.sv =====
// Port checker for the RGB to HSV converter, bound to the top level.
`timescale 1ns / 1ps

module rgb2hsv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    localparam int CW = rgb2hsv_pkg::ChanW;

    logic [CW-1:0] hue;
    logic [CW-1:0] sat;
    logic [CW-1:0] val;

    assign hue = m_tdata[CW-1:0];
    assign sat = m_tdata[2*CW-1:CW];
    assign val = m_tdata[3*CW-1:2*CW];

    // A stalled result transfer keeps its valid and its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A grey or black result carries zero hue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && sat == '0 |-> hue == '0)
        else $error("nonzero hue with zero saturation");

    // A black result carries zero saturation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && val == '0 |-> sat == '0)
        else $error("nonzero saturation with zero brightness");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rgb_to_hsv_converter_core rgb2hsv_checker u_rgb2hsv_checker (.*);
